FILE: rtl/core/vertex_affine_transform_bbox_defines.svh
// Assertion macros used by vertex_affine_transform_bbox.sv to check its own logic.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef VERTEX_AFFINE_TRANSFORM_BBOX_DEFINES_SVH
`define VERTEX_AFFINE_TRANSFORM_BBOX_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VAT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vat: check failed");

// Consequent must hold in the cycle after the antecedent.
`define VAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vat: check failed");

`endif

FILE: rtl/core/vat_pkg.sv
`default_nettype none

package vat_pkg;

    // Default parameter values.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int GROUP_SIZE_DEF  = 4;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_XYZ       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION_XYZ = 3'd4;

    // Sequencer step counter.
    localparam int SEQ_CNT_W = 4;
    localparam logic [SEQ_CNT_W-1:0] SEQ_LAST = 4'd13;

    // Rounding offsets for the two fixed-point shifts.
    localparam int RND8_BIAS  = 128;
    localparam int RND14_BIAS = 8192;

    // Configuration registers, unpacked into their fields.
    typedef struct packed {
        logic [2:0][15:0]       scale;  // unsigned Q8.8, x at index 0
        logic [2:0][2:0][15:0]  rot;    // rot[row][col], signed Q2.14
        logic [2:0][19:0]       trans;  // signed Q12.8, x at index 0
    } vat_cfg_t;

    localparam vat_cfg_t CFG_RESET = '{
        scale: 48'h0A00_1400_1400,
        rot:   {48'h4000_0000_0000, 48'h0000_4000_0000, 48'h0000_0000_4000},
        trans: 60'h0
    };

    // Datapath controls issued by the sequencer for one cycle.
    typedef struct packed {
        logic       mul_en;     // load the product register
        logic       mul_scale;  // scale product rather than matrix product
        logic [1:0] mul_axis;
        logic [1:0] mul_row;
        logic       scl_wr;     // round the product into a scaled coordinate
        logic [1:0] scl_axis;
        logic       acc_en;     // add the product into the accumulator
        logic       acc_first;  // start a new row sum
        logic       tot_wr;     // capture the finished row sum
        logic       fin_en;     // translate and saturate a row
        logic [1:0] fin_row;
    } vat_ctrl_t;

    // Bounding box and grouping status for the vertex being finished.
    typedef struct packed {
        logic               quad_end;
        logic               box_valid;
        logic signed [31:0] min_x;
        logic signed [31:0] max_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_y;
        logic               incomplete;
    } vat_box_t;

endpackage

`default_nettype wire

FILE: rtl/core/vat_if.sv
`default_nettype none

// Vertex input channel.
interface vat_in_if #(
    parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic                          last_vertex;

    modport source (output valid, in_x, in_y, in_z, last_vertex, input ready);
    modport sink   (input valid, in_x, in_y, in_z, last_vertex, output ready);
endinterface

// Transformed vertex output channel.
interface vat_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               quad_end;
    logic               box_valid;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_y;
    logic               incomplete_quad;

    modport source (output valid, out_x, out_y, out_z, quad_end, box_valid,
                    box_min_x, box_max_x, box_min_y, box_max_y, incomplete_quad,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, quad_end, box_valid,
                    box_min_x, box_max_x, box_min_y, box_max_y, incomplete_quad,
                    output ready);
endinterface

// Configuration write channel.
interface vat_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [vat_pkg::CFG_IDX_W-1:0]   index;
    logic [vat_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/vertex_affine_transform_bbox.sv
// Channel   Direction  Contents
// vtx_in    sink       in_x, in_y, in_z (signed Q8.8), last_vertex
// vtx_out   source     out_x/y/z (Q24.8), quad_end, box_valid, corners, incomplete_quad
// cfg       sink       index, data: writes one configuration register
//
// Each vertex is accepted in the idle state; in the run state the single shared
// multiplier forms three scale and nine matrix products, then drains its pipeline,
// and the final state loads the output register. No new vertex is taken until the
// block is idle again. A result that is not taken holds the block in its final
// state until the output register is free. Reset restores the identity matrix, the
// default scales and an empty box. Configuration writes are taken in every cycle.
`default_nettype none

`include "vertex_affine_transform_bbox_defines.svh"

module vertex_affine_transform_bbox #(
    parameter int GROUP_SIZE  = vat_pkg::GROUP_SIZE_DEF,
    parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    vat_in_if.sink    vtx_in,
    vat_out_if.source vtx_out,
    vat_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } vat_state_t;

    vat_state_t                        state_reg;
    vat_state_t                        state_next;
    logic [vat_pkg::SEQ_CNT_W-1:0]     cnt_reg;
    logic [vat_pkg::SEQ_CNT_W-1:0]     cnt_next;
    vat_pkg::vat_ctrl_t                ctrl;
    vat_pkg::vat_cfg_t                 cfg_reg;
    vat_pkg::vat_box_t                 box;
    logic signed [COORD_WIDTH-1:0]     crd_x_reg;
    logic signed [COORD_WIDTH-1:0]     crd_y_reg;
    logic signed [COORD_WIDTH-1:0]     crd_z_reg;
    logic                              last_reg;
    logic signed [31:0]                res_x;
    logic signed [31:0]                res_y;
    logic signed [31:0]                res_z;
    logic                              in_fire;
    logic                              fin_fire;
    logic                              out_valid_reg;
    logic signed [31:0]                out_x_reg;
    logic signed [31:0]                out_y_reg;
    logic signed [31:0]                out_z_reg;
    vat_pkg::vat_box_t                 out_box_reg;
    logic                              out_box_shown;
    logic                              out_box_ordered;

    // Handshakes.
    assign vtx_in.ready = (state_reg == ST_IDLE);
    assign in_fire      = vtx_in.valid && vtx_in.ready;
    assign fin_fire     = (state_reg == ST_FIN) && (!out_valid_reg || vtx_out.ready);
    assign cfg.ready    = 1'b1;

    // Sequencer state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + vat_pkg::SEQ_CNT_W'(1);
                if (cnt_reg == vat_pkg::SEQ_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (fin_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Step schedule: products in steps 0 to 11, each consumed in the step after it;
    // a row sum is finished in the step after it is captured.
    always_comb
    begin
        ctrl = '0;
        if (state_reg == ST_RUN)
        begin
            unique case (cnt_reg)
                4'd0:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_scale = 1'b1; ctrl.mul_axis = 2'd0;
                end
                4'd1:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_scale = 1'b1; ctrl.mul_axis = 2'd1;
                    ctrl.scl_wr = 1'b1; ctrl.scl_axis = 2'd0;
                end
                4'd2:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_scale = 1'b1; ctrl.mul_axis = 2'd2;
                    ctrl.scl_wr = 1'b1; ctrl.scl_axis = 2'd1;
                end
                4'd3:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd0; ctrl.mul_axis = 2'd0;
                    ctrl.scl_wr = 1'b1; ctrl.scl_axis = 2'd2;
                end
                4'd4:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd0; ctrl.mul_axis = 2'd1;
                    ctrl.acc_en = 1'b1; ctrl.acc_first = 1'b1;
                end
                4'd5:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd0; ctrl.mul_axis = 2'd2;
                    ctrl.acc_en = 1'b1;
                end
                4'd6:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd1; ctrl.mul_axis = 2'd0;
                    ctrl.acc_en = 1'b1; ctrl.tot_wr = 1'b1;
                end
                4'd7:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd1; ctrl.mul_axis = 2'd1;
                    ctrl.acc_en = 1'b1; ctrl.acc_first = 1'b1;
                    ctrl.fin_en = 1'b1; ctrl.fin_row = 2'd0;
                end
                4'd8:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd1; ctrl.mul_axis = 2'd2;
                    ctrl.acc_en = 1'b1;
                end
                4'd9:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd2; ctrl.mul_axis = 2'd0;
                    ctrl.acc_en = 1'b1; ctrl.tot_wr = 1'b1;
                end
                4'd10:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd2; ctrl.mul_axis = 2'd1;
                    ctrl.acc_en = 1'b1; ctrl.acc_first = 1'b1;
                    ctrl.fin_en = 1'b1; ctrl.fin_row = 2'd1;
                end
                4'd11:
                begin
                    ctrl.mul_en = 1'b1; ctrl.mul_row = 2'd2; ctrl.mul_axis = 2'd2;
                    ctrl.acc_en = 1'b1;
                end
                4'd12:
                begin
                    ctrl.acc_en = 1'b1; ctrl.tot_wr = 1'b1;
                end
                4'd13:
                begin
                    ctrl.fin_en = 1'b1; ctrl.fin_row = 2'd2;
                end
                default:
                begin
                    ctrl = '0;
                end
            endcase
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= vat_pkg::CFG_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                vat_pkg::REG_SCALE_XYZ:       cfg_reg.scale  <= cfg.data[47:0];
                vat_pkg::REG_ROT_ROW0:        cfg_reg.rot[0] <= cfg.data[47:0];
                vat_pkg::REG_ROT_ROW1:        cfg_reg.rot[1] <= cfg.data[47:0];
                vat_pkg::REG_ROT_ROW2:        cfg_reg.rot[2] <= cfg.data[47:0];
                vat_pkg::REG_TRANSLATION_XYZ: cfg_reg.trans  <= cfg.data[59:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            crd_x_reg <= vtx_in.in_x;
            crd_y_reg <= vtx_in.in_y;
            crd_z_reg <= vtx_in.in_z;
            last_reg  <= vtx_in.last_vertex;
        end
    end

    vat_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk   (clk),
        .cfg   (cfg_reg),
        .ctrl  (ctrl),
        .crd_x (crd_x_reg),
        .crd_y (crd_y_reg),
        .crd_z (crd_z_reg),
        .res_x (res_x),
        .res_y (res_y),
        .res_z (res_z)
    );

    vat_bbox #(
        .GROUP_SIZE (GROUP_SIZE)
    ) u_bbox (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (fin_fire),
        .last   (last_reg),
        .res_x  (res_x),
        .res_y  (res_y),
        .box    (box)
    );

    // Output register: holds a result until its transaction completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (vtx_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_fire)
        begin
            out_x_reg   <= res_x;
            out_y_reg   <= res_y;
            out_z_reg   <= res_z;
            out_box_reg <= box;
        end
    end

    assign vtx_out.valid           = out_valid_reg;
    assign vtx_out.out_x           = out_x_reg;
    assign vtx_out.out_y           = out_y_reg;
    assign vtx_out.out_z           = out_z_reg;
    assign vtx_out.quad_end        = out_box_reg.quad_end;
    assign vtx_out.box_valid       = out_box_reg.box_valid;
    assign vtx_out.box_min_x       = out_box_reg.min_x;
    assign vtx_out.box_max_x       = out_box_reg.max_x;
    assign vtx_out.box_min_y       = out_box_reg.min_y;
    assign vtx_out.box_max_y       = out_box_reg.max_y;
    assign vtx_out.incomplete_quad = out_box_reg.incomplete;

    // A reported box must have its corners in order.
    assign out_box_shown   = vtx_out.valid && vtx_out.box_valid;
    assign out_box_ordered = (vtx_out.box_min_x <= vtx_out.box_max_x)
                             && (vtx_out.box_min_y <= vtx_out.box_max_y);

    // Checks on the sequencer and the box.
    `VAT_ASSERT_NEXT(a_busy_after_accept, in_fire, !vtx_in.ready)
    `VAT_ASSERT_SAME(a_result_from_fin, $rose(out_valid_reg), $past(state_reg) == ST_FIN)
    `VAT_ASSERT_SAME(a_box_ordered, out_box_shown, out_box_ordered)

endmodule

`default_nettype wire

FILE: rtl/core/vat_datapath.sv
`default_nettype none

module vat_datapath #(
    parameter int COORD_WIDTH = vat_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire vat_pkg::vat_cfg_t             cfg,
    input  wire vat_pkg::vat_ctrl_t            ctrl,
    input  wire logic signed [COORD_WIDTH-1:0] crd_x,
    input  wire logic signed [COORD_WIDTH-1:0] crd_y,
    input  wire logic signed [COORD_WIDTH-1:0] crd_z,
    output logic signed [31:0]                 res_x,
    output logic signed [31:0]                 res_y,
    output logic signed [31:0]                 res_z
);

    // Scaled coordinate, product, row sum, shifted row sum and translated sum widths.
    localparam int SC_W  = COORD_WIDTH + 10;
    localparam int P_W   = SC_W + 17;
    localparam int ACC_W = P_W + 2;
    localparam int SH_W  = ACC_W - 14;
    localparam int SUM_W = (SH_W + 1 > 33) ? SH_W + 1 : 33;

    logic signed [COORD_WIDTH-1:0] crd [3];
    logic signed [SC_W-1:0]        scaled_reg [3];
    logic signed [SC_W-1:0]        mul_a;
    logic signed [16:0]            mul_b;
    logic signed [P_W-1:0]         prod_reg;
    logic signed [P_W-1:0]         rnd8;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [ACC_W-1:0]       tot_reg;
    logic signed [SH_W-1:0]        shifted;
    logic signed [19:0]            trans;
    logic signed [SUM_W-1:0]       sum;
    logic [31:0]                   sat;
    logic signed [31:0]            res_reg [3];

    assign crd[0] = crd_x;
    assign crd[1] = crd_y;
    assign crd[2] = crd_z;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        if (ctrl.mul_scale)
        begin
            mul_a = SC_W'(crd[ctrl.mul_axis]);
            mul_b = {1'b0, cfg.scale[ctrl.mul_axis]};
        end
        else
        begin
            mul_a = scaled_reg[ctrl.mul_axis];
            mul_b = 17'($signed(cfg.rot[ctrl.mul_row][ctrl.mul_axis]));
        end
    end

    // Rounding of a scale product, and the running row sum. The row sum
    // starts from the rounding offset, so the final shift needs no add.
    assign rnd8     = prod_reg + P_W'(vat_pkg::RND8_BIAS);
    assign acc_next = (ctrl.acc_first ? ACC_W'(vat_pkg::RND14_BIAS) : acc_reg)
                      + ACC_W'(prod_reg);

    // Translation and saturation of a finished row.
    assign shifted = tot_reg[ACC_W-1:14];
    assign trans   = cfg.trans[ctrl.fin_row];
    assign sum     = SUM_W'(shifted) + SUM_W'(trans);

    always_comb
    begin
        if ((&sum[SUM_W-1:31]) || !(|sum[SUM_W-1:31]))
        begin
            sat = sum[31:0];
        end
        else
        begin
            sat = {sum[SUM_W-1], {31{~sum[SUM_W-1]}}};
        end
    end

    // Multiplier, scaled coordinates, accumulator and results.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (ctrl.scl_wr)
        begin
            scaled_reg[ctrl.scl_axis] <= rnd8[SC_W+7:8];
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (ctrl.tot_wr)
        begin
            tot_reg <= acc_next;
        end
        if (ctrl.fin_en)
        begin
            res_reg[ctrl.fin_row] <= sat;
        end
    end

    assign res_x = res_reg[0];
    assign res_y = res_reg[1];
    assign res_z = res_reg[2];

endmodule

`default_nettype wire

FILE: rtl/core/vat_bbox.sv
`default_nettype none

module vat_bbox #(
    parameter int GROUP_SIZE = vat_pkg::GROUP_SIZE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               update,
    input  wire logic               last,
    input  wire logic signed [31:0] res_x,
    input  wire logic signed [31:0] res_y,
    output vat_pkg::vat_box_t       box
);

    localparam int QP_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
    localparam logic [QP_W-1:0] QP_LAST = QP_W'(GROUP_SIZE - 1);

    logic               first_pending_reg;
    logic [QP_W-1:0]    quad_pos_reg;
    logic [QP_W-1:0]    quad_pos_next;
    logic               qend;
    logic signed [31:0] min_x_reg;
    logic signed [31:0] max_x_reg;
    logic signed [31:0] min_y_reg;
    logic signed [31:0] max_y_reg;
    logic signed [31:0] min_x_next;
    logic signed [31:0] max_x_next;
    logic signed [31:0] min_y_next;
    logic signed [31:0] max_y_next;

    // Group position of this vertex.
    assign qend          = (quad_pos_reg == QP_LAST);
    assign quad_pos_next = qend ? '0 : quad_pos_reg + QP_W'(1);

    // Box including this vertex; the first vertex of a list sets all corners.
    assign min_x_next = (first_pending_reg || res_x < min_x_reg) ? res_x : min_x_reg;
    assign max_x_next = (first_pending_reg || res_x > max_x_reg) ? res_x : max_x_reg;
    assign min_y_next = (first_pending_reg || res_y < min_y_reg) ? res_y : min_y_reg;
    assign max_y_next = (first_pending_reg || res_y > max_y_reg) ? res_y : max_y_reg;

    // Status reported with the vertex; box fields read zero except on the last.
    always_comb
    begin
        box.quad_end   = qend;
        box.box_valid  = last;
        box.min_x      = last ? min_x_next : '0;
        box.max_x      = last ? max_x_next : '0;
        box.min_y      = last ? min_y_next : '0;
        box.max_y      = last ? max_y_next : '0;
        box.incomplete = last && !qend;
    end

    // Box and group state; the end of a list clears it for the next one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
            quad_pos_reg      <= '0;
            min_x_reg         <= '0;
            max_x_reg         <= '0;
            min_y_reg         <= '0;
            max_y_reg         <= '0;
        end
        else if (update)
        begin
            if (last)
            begin
                first_pending_reg <= 1'b1;
                quad_pos_reg      <= '0;
                min_x_reg         <= '0;
                max_x_reg         <= '0;
                min_y_reg         <= '0;
                max_y_reg         <= '0;
            end
            else
            begin
                first_pending_reg <= 1'b0;
                quad_pos_reg      <= quad_pos_next;
                min_x_reg         <= min_x_next;
                max_x_reg         <= max_x_next;
                min_y_reg         <= min_y_next;
                max_y_reg         <= max_y_next;
            end
        end
    end

endmodule

`default_nettype wire
